[sv/dsf_pkg.sv]
// shared widths, register indexes and pipeline side-band types for the spring force block
package dsf_pkg;

  localparam int unsigned REG_W       = 31;
  localparam int unsigned DIFF_W      = 33;
  localparam int unsigned SQ_W        = 66;
  localparam int unsigned LEN_W       = 34;
  localparam int unsigned EXT_W       = 35;
  localparam int unsigned UNIT_W      = 17;
  localparam int unsigned SQRT_STAGES = 34;
  localparam int unsigned DIV_STAGES  = 17;

  // 0.01 in raw q16.16, rounded down
  localparam logic [LEN_W-1:0] MIN_LEN = 34'd655;

  typedef enum logic [1:0] {
    REG_REST  = 2'd0,
    REG_STIFF = 2'd1,
    REG_DAMP  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                     neg_x;
    logic                     neg_y;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;
    logic signed [DIFF_W-1:0] rvx;
    logic signed [DIFF_W-1:0] rvy;
  } sq_side_t;

  typedef struct packed {
    logic                     l_ok;
    logic signed [EXT_W-1:0]  ext;
    logic                     neg_x;
    logic                     neg_y;
    logic signed [DIFF_W-1:0] rvx;
    logic signed [DIFF_W-1:0] rvy;
  } div_side_t;

  typedef struct packed {
    logic signed [31:0] force1_x;
    logic signed [31:0] force1_y;
    logic signed [31:0] force2_x;
    logic signed [31:0] force2_y;
    logic [31:0]        spring_energy;
  } result_t;

endpackage

[sv/dsf_in_if.sv]
// input channel: end point positions and velocities
interface dsf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point1_x;
  logic signed [31:0] point1_y;
  logic signed [31:0] point2_x;
  logic signed [31:0] point2_y;
  logic signed [31:0] vel1_x;
  logic signed [31:0] vel1_y;
  logic signed [31:0] vel2_x;
  logic signed [31:0] vel2_y;

  modport source (output valid, point1_x, point1_y, point2_x, point2_y,
                  vel1_x, vel1_y, vel2_x, vel2_y, input ready);
  modport sink (input valid, point1_x, point1_y, point2_x, point2_y,
                vel1_x, vel1_y, vel2_x, vel2_y, output ready);
endinterface

[sv/dsf_out_if.sv]
// result channel: forces on both ends and stored energy
interface dsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force1_x;
  logic signed [31:0] force1_y;
  logic signed [31:0] force2_x;
  logic signed [31:0] force2_y;
  logic [31:0]        spring_energy;

  modport source (output valid, force1_x, force1_y, force2_x, force2_y,
                  spring_energy, input ready);
  modport sink (input valid, force1_x, force1_y, force2_x, force2_y,
                spring_energy, output ready);
endinterface

[sv/dsf_cfg_if.sv]
// configuration write channel
interface dsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/damped_spring_force_2d.sv]
// top level of the damped 2-d spring force pipeline
// Damped spring force in signed Q16.16: each input transaction carries both end
// positions and velocities, each output transaction the force on either end
// and the stored energy. The block takes one transaction every cycle unless a
// stalled output holds it. A transaction passes the differences and squares,
// the bit-per-stage square root of the 66-bit length squared, the two-lane
// bit-per-stage direction divider, the products, sums and saturation, and
// the output register. A stalled output holds the whole pipeline only when
// its last stage holds a result, so bubbles still drain. Register writes take
// effect at once; the user keeps them to an idle block, the block does not enforce it.
module damped_spring_force_2d (
  input  logic        clk,
  input  logic        rst_n,
  dsf_in_if.sink      in_ch,
  dsf_out_if.source   out_ch,
  dsf_cfg_if.sink     cfg_ch
);
  // configuration registers
  logic [dsf_pkg::REG_W-1:0] rest_r, stiff_r, damp_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= 31'd65536;
      stiff_r <= '0;
      damp_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dsf_pkg::REG_REST:  rest_r  <= cfg_ch.data;
        dsf_pkg::REG_STIFF: stiff_r <= cfg_ch.data;
        dsf_pkg::REG_DAMP:  damp_r  <= cfg_ch.data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // global advance: blocked only by a full last stage facing a stalled output
  logic             en;
  logic             fo_valid;
  dsf_pkg::result_t fo_data;
  logic             out_v_r;
  dsf_pkg::result_t out_r;
  logic             ld;

  assign en          = !fo_valid || !out_v_r || out_ch.ready;
  assign ld          = fo_valid && (!out_v_r || out_ch.ready);
  assign in_ch.ready = en;

  // stage p0: position and velocity differences, exact in 33 bits
  logic                 v0_r;
  logic signed [32:0]   dx_r, dy_r, rvx_r, rvy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= {in_ch.point2_x[31], in_ch.point2_x} - {in_ch.point1_x[31], in_ch.point1_x};
      dy_r  <= {in_ch.point2_y[31], in_ch.point2_y} - {in_ch.point1_y[31], in_ch.point1_y};
      rvx_r <= {in_ch.vel2_x[31], in_ch.vel2_x} - {in_ch.vel1_x[31], in_ch.vel1_x};
      rvy_r <= {in_ch.vel2_y[31], in_ch.vel2_y} - {in_ch.vel1_y[31], in_ch.vel1_y};
    end
  end

  // stage p1: magnitudes and their squares
  logic                v1_r;
  logic [65:0]         sqx_r, sqy_r;
  dsf_pkg::sq_side_t   sq_side_r;
  logic [32:0]         ax, ay;

  assign ax = dx_r[32] ? 33'(-dx_r) : dx_r;
  assign ay = dy_r[32] ? 33'(-dy_r) : dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r           <= 66'(ax) * 66'(ax);
      sqy_r           <= 66'(ay) * 66'(ay);
      sq_side_r.neg_x <= dx_r[32];
      sq_side_r.neg_y <= dy_r[32];
      sq_side_r.ax    <= ax;
      sq_side_r.ay    <= ay;
      sq_side_r.rvx   <= rvx_r;
      sq_side_r.rvy   <= rvy_r;
    end
  end

  // length by pipelined square root
  logic                              sq_valid;
  logic [dsf_pkg::LEN_W-1:0]         len;
  dsf_pkg::sq_side_t                 sq_out;

  dsf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .sq_a      (sqx_r),
    .sq_b      (sqy_r),
    .in_side   (sq_side_r),
    .out_valid (sq_valid),
    .root      (len),
    .out_side  (sq_out)
  );

  // extension from rest length and the short-spring check
  dsf_pkg::div_side_t div_in;

  always_comb begin
    div_in.l_ok  = len >= dsf_pkg::MIN_LEN;
    div_in.ext   = $signed({1'b0, len}) - $signed({4'h0, rest_r});
    div_in.neg_x = sq_out.neg_x;
    div_in.neg_y = sq_out.neg_y;
    div_in.rvx   = sq_out.rvx;
    div_in.rvy   = sq_out.rvy;
  end

  // unit direction |d| / l in q16.16
  logic                              dv_valid;
  logic [dsf_pkg::UNIT_W-1:0]        unit_x, unit_y;
  dsf_pkg::div_side_t                div_out;

  dsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .num_x     (sq_out.ax),
    .num_y     (sq_out.ay),
    .den       (len),
    .in_side   (div_in),
    .out_valid (dv_valid),
    .quo_x     (unit_x),
    .quo_y     (unit_y),
    .out_side  (div_out)
  );

  // spring, damper and energy terms
  dsf_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .unit_x    (unit_x),
    .unit_y    (unit_y),
    .in_side   (div_out),
    .stiffness (stiff_r),
    .damping   (damp_r),
    .out_valid (fo_valid),
    .result    (fo_data)
  );

  // output register parts the pipeline from the sink
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_r <= fo_data;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.force1_x      = out_r.force1_x;
  assign out_ch.force1_y      = out_r.force1_y;
  assign out_ch.force2_x      = out_r.force2_x;
  assign out_ch.force2_y      = out_r.force2_y;
  assign out_ch.spring_energy = out_r.spring_energy;

`ifndef SYNTH
  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_v_r)
    else $error("output valid after reset");

  // a full last stage facing a stalled output must hold the input side
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fo_valid && out_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted into a stalled full pipeline");

  // a new result only comes from a valid last pipeline stage
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(fo_valid))
    else $error("output loaded without a pipeline result");
`endif
endmodule

[sv/dsf_sqrt.sv]
// pipelined integer square root, one result bit per stage
module dsf_sqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [dsf_pkg::SQ_W-1:0]            sq_a,
  input  logic [dsf_pkg::SQ_W-1:0]            sq_b,
  input  dsf_pkg::sq_side_t                   in_side,
  output logic                                out_valid,
  output logic [dsf_pkg::LEN_W-1:0]           root,
  output dsf_pkg::sq_side_t                   out_side
);
  localparam int unsigned N  = dsf_pkg::SQRT_STAGES;
  localparam int unsigned RW = dsf_pkg::SQ_W;
  localparam int unsigned LW = dsf_pkg::LEN_W;
  localparam int unsigned TW = RW + 2;

  logic [N:0]          v_r;
  logic [RW-1:0]       rem_r  [0:N];
  logic [LW-1:0]       root_r [0:N];
  dsf_pkg::sq_side_t   side_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= sq_a + sq_b;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    localparam int unsigned B = N - k;
    logic [TW-1:0] trial;
    logic          take;
    assign trial = ({{(TW-LW){1'b0}}, root_r[k-1]} << (B + 1)) + ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
    assign take  = {2'b00, rem_r[k-1]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? rem_r[k-1] - trial[RW-1:0] : rem_r[k-1];
        root_r[k] <= take ? root_r[k-1] | ({{(LW-1){1'b0}}, 1'b1} << B) : root_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[N];
  assign root      = root_r[N];
  assign out_side  = side_r[N];
endmodule

[sv/dsf_div.sv]
// two-lane pipelined restoring divider for the unit direction, one quotient bit per stage
module dsf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [dsf_pkg::DIFF_W-1:0]        num_x,
  input  logic [dsf_pkg::DIFF_W-1:0]        num_y,
  input  logic [dsf_pkg::LEN_W-1:0]         den,
  input  dsf_pkg::div_side_t                in_side,
  output logic                              out_valid,
  output logic [dsf_pkg::UNIT_W-1:0]        quo_x,
  output logic [dsf_pkg::UNIT_W-1:0]        quo_y,
  output dsf_pkg::div_side_t                out_side
);
  localparam int unsigned N  = dsf_pkg::DIV_STAGES;
  localparam int unsigned QW = dsf_pkg::UNIT_W;
  localparam int unsigned LW = dsf_pkg::LEN_W;
  localparam int unsigned RW = dsf_pkg::DIFF_W + 17;
  localparam int unsigned TW = RW + 1;

  logic [N:0]          v_r;
  logic [RW-1:0]       rx_r   [0:N];
  logic [RW-1:0]       ry_r   [0:N];
  logic [QW-1:0]       qx_r   [0:N];
  logic [QW-1:0]       qy_r   [0:N];
  logic [LW-1:0]       den_r  [0:N];
  dsf_pkg::div_side_t  side_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]   <= {1'b0, num_x, 16'h0000};
      ry_r[0]   <= {1'b0, num_y, 16'h0000};
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      den_r[0]  <= den;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    localparam int unsigned B = N - k;
    logic [TW-1:0] trial;
    logic          take_x;
    logic          take_y;
    logic [QW-1:0] qbit;
    assign trial  = {{(TW-LW){1'b0}}, den_r[k-1]} << B;
    assign take_x = {1'b0, rx_r[k-1]} >= trial;
    assign take_y = {1'b0, ry_r[k-1]} >= trial;
    assign qbit   = {{(QW-1){1'b0}}, 1'b1} << B;
    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k]   <= take_x ? rx_r[k-1] - trial[RW-1:0] : rx_r[k-1];
        ry_r[k]   <= take_y ? ry_r[k-1] - trial[RW-1:0] : ry_r[k-1];
        qx_r[k]   <= take_x ? qx_r[k-1] | qbit : qx_r[k-1];
        qy_r[k]   <= take_y ? qy_r[k-1] | qbit : qy_r[k-1];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[N];
  assign quo_x     = qx_r[N];
  assign quo_y     = qy_r[N];
  assign out_side  = side_r[N];
endmodule

[sv/dsf_force.sv]
// force and energy products, signed sums and saturation in four stages
module dsf_force (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dsf_pkg::UNIT_W-1:0]    unit_x,
  input  logic [dsf_pkg::UNIT_W-1:0]    unit_y,
  input  dsf_pkg::div_side_t            in_side,
  input  logic [dsf_pkg::REG_W-1:0]     stiffness,
  input  logic [dsf_pkg::REG_W-1:0]     damping,
  output logic                          out_valid,
  output dsf_pkg::result_t              result
);
  function automatic logic [31:0] sat_s32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -52'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  logic [3:0] v_r;

  // stage 1
  logic [50:0] t1x_r, t1y_r;
  logic [67:0] ex_r;
  logic [63:0] dpx_r, dpy_r;
  logic        snx_r, sny_r, dnx_r, dny_r;
  // stage 2
  logic [65:0] spx_r, spy_r;
  logic [62:0] elo_r;
  logic [49:0] ehi_r;
  logic [47:0] dmx_r, dmy_r;
  logic        snx2_r, sny2_r, dnx2_r, dny2_r;
  // stage 3
  logic signed [51:0] fx_r, fy_r;
  logic [31:0]        en_r;
  // stage 4
  dsf_pkg::result_t   res_r;

  logic signed [34:0] ext_neg;
  logic [33:0]        ext_mag;
  logic [16:0]        ux, uy;
  logic [32:0]        rvx_mag, rvy_mag;
  logic [51:0]        e_shift;
  logic [50:0]        e_clamp;
  logic [81:0]        e_sum;
  logic [64:0]        e_q;
  logic signed [51:0] spx_s, spy_s, dmx_s, dmy_s;

  always_comb begin
    ext_neg = -in_side.ext;
    ext_mag = in_side.ext[34] ? ext_neg[33:0] : in_side.ext[33:0];
    ux      = in_side.l_ok ? unit_x : '0;
    uy      = in_side.l_ok ? unit_y : '0;
    rvx_mag = in_side.rvx[32] ? 33'(-in_side.rvx) : in_side.rvx;
    rvy_mag = in_side.rvy[32] ? 33'(-in_side.rvy) : in_side.rvy;
    e_shift = ex_r[67:16];
    // past 2^50 the energy saturates anyway unless stiffness is zero
    e_clamp = (e_shift >= 52'h4_0000_0000_0000) ? 51'h4_0000_0000_0000 : e_shift[50:0];
    e_sum   = {19'h0, elo_r} + {ehi_r, 32'h0};
    e_q     = e_sum[81:17];
    spx_s   = {2'b00, spx_r[65:16]};
    spy_s   = {2'b00, spy_r[65:16]};
    dmx_s   = {4'h0, dmx_r};
    dmy_s   = {4'h0, dmy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1x_r  <= 51'(ux) * 51'(ext_mag);
      t1y_r  <= 51'(uy) * 51'(ext_mag);
      ex_r   <= 68'(ext_mag) * 68'(ext_mag);
      dpx_r  <= 64'(rvx_mag) * 64'(damping);
      dpy_r  <= 64'(rvy_mag) * 64'(damping);
      snx_r  <= in_side.neg_x ^ in_side.ext[34];
      sny_r  <= in_side.neg_y ^ in_side.ext[34];
      dnx_r  <= in_side.rvx[32];
      dny_r  <= in_side.rvy[32];

      spx_r  <= 66'(t1x_r[50:16]) * 66'(stiffness);
      spy_r  <= 66'(t1y_r[50:16]) * 66'(stiffness);
      elo_r  <= 63'(e_clamp[31:0]) * 63'(stiffness);
      ehi_r  <= 50'(e_clamp[50:32]) * 50'(stiffness);
      dmx_r  <= dpx_r[63:16];
      dmy_r  <= dpy_r[63:16];
      snx2_r <= snx_r;
      sny2_r <= sny_r;
      dnx2_r <= dnx_r;
      dny2_r <= dny_r;

      fx_r   <= (snx2_r ? -spx_s : spx_s) + (dnx2_r ? -dmx_s : dmx_s);
      fy_r   <= (sny2_r ? -spy_s : spy_s) + (dny2_r ? -dmy_s : dmy_s);
      en_r   <= (|e_q[64:32]) ? 32'hffff_ffff : e_q[31:0];

      res_r.force1_x      <= sat_s32(fx_r);
      res_r.force1_y      <= sat_s32(fy_r);
      res_r.force2_x      <= sat_s32(-fx_r);
      res_r.force2_y      <= sat_s32(-fy_r);
      res_r.spring_energy <= en_r;
    end
  end

  assign out_valid = v_r[3];
  assign result    = res_r;
endmodule

[dv/dsf_tb_if.sv]
// testbench item types for the spring force block
`timescale 1ns / 100ps
package dsf_tb_pkg;

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } spring_item_t;

endpackage

[dv/tb_damped_spring_force_2d.sv]
// testbench for the damped 2-d spring force block: directed table plus random, predictor checked
`timescale 1ns / 100ps
module tb_damped_spring_force_2d;

  localparam int unsigned PIPE_LAT = 60;
  localparam int unsigned WATCHDOG = 20000;
  localparam int unsigned N_RANDOM = 1500;
  localparam logic [63:0] TERM_CAP = 64'h2000_0000_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  dsf_in_if  in_ch ();
  dsf_out_if out_ch ();
  dsf_cfg_if cfg_ch ();

  damped_spring_force_2d dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predictor copy of the registers
  logic [30:0] rest_q = 31'd65536;
  logic [30:0] stiff_q = '0;
  logic [30:0] damp_q = '0;

  dsf_pkg::result_t expected_forces[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit out_stall_en = 1'b1;

  // (a*b)>>16 on magnitudes, capped at TERM_CAP
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [127:0] r;
    p = a * b;
    r = p >> 16;
    if (r > TERM_CAP) return TERM_CAP;
    return r[63:0];
  endfunction

  // floor of the euclidean length of a 33-bit difference vector
  function automatic logic [63:0] spring_length(logic [63:0] ax, logic [63:0] ay);
    logic [127:0] sum;
    logic [127:0] c;
    logic [63:0] r;
    sum = ax * ax + ay * ay;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= sum) r = c[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] axis_force(logic signed [63:0] d, logic [63:0] l,
                                                    logic signed [63:0] ext,
                                                    logic signed [63:0] rv);
    logic [63:0] u;
    logic [63:0] t;
    logic signed [63:0] spring;
    logic signed [63:0] damper;
    spring = 0;
    if (l >= 64'd655) begin
      u = (mag64(d) << 16) / l;
      t = qmul(qmul(u, mag64(ext)), {33'd0, stiff_q});
      spring = ((d < 0) != (ext < 0)) ? -$signed(t) : $signed(t);
    end
    t = qmul(mag64(rv), {33'd0, damp_q});
    damper = (rv < 0) ? -$signed(t) : $signed(t);
    return spring + damper;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic dsf_pkg::result_t predict_forces(dsf_tb_pkg::spring_item_t it);
    logic signed [63:0] dx, dy, rvx, rvy, ext, fx, fy;
    logic [63:0] l, e;
    dsf_pkg::result_t r;
    dx = 64'(it.p2x) - 64'(it.p1x);
    dy = 64'(it.p2y) - 64'(it.p1y);
    rvx = 64'(it.v2x) - 64'(it.v1x);
    rvy = 64'(it.v2y) - 64'(it.v1y);
    l = spring_length(mag64(dx), mag64(dy));
    ext = $signed(l) - $signed({33'd0, rest_q});
    fx = axis_force(dx, l, ext, rvx);
    fy = axis_force(dy, l, ext, rvy);
    e = qmul(qmul(mag64(ext), mag64(ext)), {33'd0, stiff_q}) >> 1;
    r.force1_x = sat32(fx);
    r.force1_y = sat32(fy);
    r.force2_x = sat32(-fx);
    r.force2_y = sat32(-fy);
    r.spring_energy = (e > 64'hffff_ffff) ? 32'hffff_ffff : e[31:0];
    return r;
  endfunction

  // random gap length: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    unique case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic dsf_tb_pkg::spring_item_t rand_item();
    dsf_tb_pkg::spring_item_t it;
    it.p1x = rand_word();
    it.p1y = rand_word();
    it.p2x = rand_word();
    it.p2y = rand_word();
    it.v1x = rand_word();
    it.v1y = rand_word();
    it.v2x = rand_word();
    it.v2y = rand_word();
    // some short springs near the direction threshold
    if ($urandom_range(0, 9) == 0) begin
      it.p2x = it.p1x + $signed($urandom_range(0, 1400)) - 700;
      it.p2y = it.p1y + $signed($urandom_range(0, 8)) - 4;
    end
    return it;
  endfunction

  // result side: random stalls, compare each output transaction with the oldest expectation
  always @(negedge clk) begin
    if (out_stall_en && $urandom_range(0, 99) < 25) out_ch.ready <= 1'b0;
    else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    dsf_pkg::result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h %h", $time, out_ch.force1_x,
                 out_ch.force1_y, out_ch.force2_x, out_ch.force2_y, out_ch.spring_energy);
        errors++;
      end else begin
        exp_r = expected_forces.pop_front();
        if (out_ch.force1_x !== exp_r.force1_x) begin
          $display("%0t: force1_x exp %h got %h", $time, exp_r.force1_x, out_ch.force1_x);
          errors++;
        end
        if (out_ch.force1_y !== exp_r.force1_y) begin
          $display("%0t: force1_y exp %h got %h", $time, exp_r.force1_y, out_ch.force1_y);
          errors++;
        end
        if (out_ch.force2_x !== exp_r.force2_x) begin
          $display("%0t: force2_x exp %h got %h", $time, exp_r.force2_x, out_ch.force2_x);
          errors++;
        end
        if (out_ch.force2_y !== exp_r.force2_y) begin
          $display("%0t: force2_y exp %h got %h", $time, exp_r.force2_y, out_ch.force2_y);
          errors++;
        end
        if (out_ch.spring_energy !== exp_r.spring_energy) begin
          $display("%0t: spring_energy exp %h got %h", $time, exp_r.spring_energy,
                   out_ch.spring_energy);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL damped_spring_force_2d");
      $finish;
    end
  end

  // one register write transaction, predictor updated at acceptance
  task automatic write_reg(dsf_pkg::cfg_idx_t idx, logic [30:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    unique case (idx)
      dsf_pkg::REG_REST:  rest_q = val;
      dsf_pkg::REG_STIFF: stiff_q = val;
      dsf_pkg::REG_DAMP:  damp_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one input transaction; a typed expectation replaces the predictor
  task automatic send_item(dsf_tb_pkg::spring_item_t it, bit has_typed,
                           dsf_pkg::result_t typed);
    dsf_pkg::result_t pr;
    int unsigned g;
    g = gap_len();
    @(negedge clk);
    // valid stays high from the previous transaction only when there is no gap
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point1_x <= it.p1x; in_ch.point1_y <= it.p1y;
    in_ch.point2_x <= it.p2x; in_ch.point2_y <= it.p2y;
    in_ch.vel1_x <= it.v1x; in_ch.vel1_y <= it.v1y;
    in_ch.vel2_x <= it.v2x; in_ch.vel2_y <= it.v2y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pr = predict_forces(it);
    expected_forces.push_back(has_typed ? typed : pr);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  dsf_tb_pkg::spring_item_t dir_items[12];
  bit                       dir_typed[12];
  dsf_pkg::result_t         dir_res[12];

  initial begin
    dsf_tb_pkg::spring_item_t it;
    dsf_pkg::result_t none;
    dsf_pkg::result_t e_sat;
    in_ch.valid = 1'b0;
    in_ch.point1_x = '0; in_ch.point1_y = '0;
    in_ch.point2_x = '0; in_ch.point2_y = '0;
    in_ch.vel1_x = '0; in_ch.vel1_y = '0;
    in_ch.vel2_x = '0; in_ch.vel2_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = dsf_pkg::REG_REST;
    cfg_ch.data = '0;
    none = '0;
    // zero-length spring at the largest rest length: no force, energy saturated
    e_sat = '0;
    e_sat.spring_energy = 32'hffff_ffff;
    // directed table: typed results where obvious, others predicted
    dir_items[0] = '0;                       dir_typed[0] = 1; dir_res[0] = '0;
    dir_items[1] = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000};
    dir_typed[1] = 0; dir_res[1] = none;
    dir_items[2] = '{0, 0, 32'sh0001_0000, 0, 0, 0, 0, 0};
    dir_typed[2] = 0; dir_res[2] = none;
    dir_items[3] = '{0, 0, 654, 0, 0, 0, 32'sh0001_0000, 0};
    dir_typed[3] = 0; dir_res[3] = none;
    dir_items[4] = '{0, 0, 655, 0, 0, 0, 0, 32'sh0001_0000};
    dir_typed[4] = 0; dir_res[4] = none;
    dir_items[5] = '{32'sh8000_0000, 0, 32'sh7fff_ffff, 0, 0, 0, 0, 0};
    dir_typed[5] = 0; dir_res[5] = none;
    dir_items[6] = '{0, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 32'sh8000_0000, 0};
    dir_typed[6] = 0; dir_res[6] = none;
    dir_items[7] = '{32'sh0003_0000, 32'sh0004_0000, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 0, 0};
    dir_typed[7] = 0; dir_res[7] = none;
    dir_items[8] = '{-5, -5, -5, -5, -1, -1, 1, 1};
    dir_typed[8] = 0; dir_res[8] = none;
    dir_items[9] = '{32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                     32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555};
    dir_typed[9] = 0; dir_res[9] = none;
    dir_items[10] = '{32'hffff_ffff, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 0, 0};
    dir_typed[10] = 0; dir_res[10] = none;
    dir_items[11] = '{0, 0, 0, 32'sh0010_0000, 0, 0, 0, 0};
    dir_typed[11] = 0; dir_res[11] = none;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: no stiffness or damping, so everything is zero
    for (int i = 0; i < 12; i++) send_item(dir_items[i], 1, '0);
    drain();

    // extremes of the registers
    write_reg(dsf_pkg::REG_REST, 31'h7fff_ffff);
    write_reg(dsf_pkg::REG_STIFF, 31'h7fff_ffff);
    write_reg(dsf_pkg::REG_DAMP, 31'h7fff_ffff);
    for (int i = 0; i < 12; i++)
      send_item(dir_items[i], dir_typed[i], (i == 0) ? e_sat : dir_res[i]);
    drain();

    write_reg(dsf_pkg::REG_REST, 31'd0);
    write_reg(dsf_pkg::REG_STIFF, 31'd65536);
    write_reg(dsf_pkg::REG_DAMP, 31'd32768);
    for (int i = 0; i < 12; i++) send_item(dir_items[i], dir_typed[i], dir_res[i]);
    drain();
    // write to an unknown index is ignored
    write_reg(dsf_pkg::cfg_idx_t'(2'd3), 31'h1234_5678);
    send_item(dir_items[7], 0, none);
    drain();

    // random phases with fresh register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(dsf_pkg::REG_REST, (ph == 0) ? 31'd0 : 31'($urandom));
      write_reg(dsf_pkg::REG_STIFF,
                (ph == 1) ? 31'h7fff_ffff : 31'($urandom_range(0, 32'h0008_0000)));
      write_reg(dsf_pkg::REG_DAMP, (ph == 2) ? 31'd0 : 31'($urandom));
      out_stall_en = (ph != 3);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        it = rand_item();
        send_item(it, 0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS damped_spring_force_2d");
    end else begin
      $display("FAIL damped_spring_force_2d");
    end
    $finish;
  end

endmodule
